// ----- rtl/csr_pkg.sv -----
// ----------------------------------------------------------------------------
// csr_pkg
// Shared types and constants for the callback slot registry.
// ----------------------------------------------------------------------------
package csr_pkg;

  localparam int SLOT_COUNT = 4096;
  localparam int SLOT_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int CNT_W      = $clog2(SLOT_COUNT + 1);
  localparam int KEY_W      = 64;
  localparam int ADDR_W     = 64;
  localparam int IDX_OUT_W  = 12;
  localparam int STAT_W     = 3;
  localparam int OUT_BITS   = STAT_W + IDX_OUT_W + 3 * 64;
  localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

  typedef enum logic [STAT_W-1:0] {
    ST_OK      = 3'd0,
    ST_FULL    = 3'd1,
    ST_DUP     = 3'd2,
    ST_MISSING = 3'd3,
    ST_ZERO    = 3'd4
  } csr_status_t;

  typedef enum logic {
    OP_REGISTER   = 1'b0,
    OP_UNREGISTER = 1'b1
  } csr_op_t;

  typedef enum logic {
    CFG_ENTRY_BASE = 1'b0,
    CFG_HANDLER    = 1'b1
  } csr_cfg_idx_t;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_RESP
  } csr_state_t;

  typedef struct packed {
    logic ctr_clear;
    logic clr_write;
    logic accept;
    logic scan_issue;
    logic finish;
  } csr_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic scan_done;
    logic key_zero;
    logic out_free;
  } csr_sts_t;

endpackage

// ----- rtl/callback_slot_registry.sv -----
// ----------------------------------------------------------------------------
// callback_slot_registry
// Table of callback keys: register takes the lowest free slot, unregister
// clears the slot that holds the key.
// Each result waits for a full read of the key memory (a zero key skips it),
// one slot per cycle on its read port.
// One item in flight: no new input beat is taken until the last result is in the output register.
// Reset: a clearing pass writes every slot to zero, in_tready low
// meanwhile; configuration registers reset to zero.
// ----------------------------------------------------------------------------
module callback_slot_registry (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic                            cfg_index,
  input  logic [63:0]                     cfg_wdata,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [63:0]                     in_tdata,   // key
  input  logic                            in_tuser,   // operation
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // status[2:0], slot_index[14:3], entry_address[78:15],
  // write_target[142:79], write_handler[206:143], zero pad
  output logic [csr_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import csr_pkg::*;

  csr_cmd_t cmd;
  csr_sts_t sts;

  csr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  csr_dpath u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_op      (in_tuser),
    .in_key     (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

// ----- rtl/csr_ctrl.sv -----
// ----------------------------------------------------------------------------
// csr_ctrl
// Sequencer: clearing pass, item accept, slot scan and result hand-off.
// ----------------------------------------------------------------------------
module csr_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  csr_pkg::csr_sts_t sts,
  output csr_pkg::csr_cmd_t cmd
);
  import csr_pkg::*;

  csr_state_t state_r;
  csr_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr_write = 1'b1;
        if (sts.clr_last) begin
          cmd.ctr_clear = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.accept    = 1'b1;
          cmd.ctr_clear = 1'b1;
          state_nxt     = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan_issue = 1'b1;
        if (sts.key_zero || sts.scan_done) begin
          state_nxt = S_RESP;
        end
      end
      S_RESP: begin
        if (sts.out_free) begin
          cmd.finish    = 1'b1;
          cmd.ctr_clear = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

endmodule

// ----- rtl/csr_dpath.sv -----
// ----------------------------------------------------------------------------
// csr_dpath
// Key memory, scan counter, match and free trackers, result register.
// ----------------------------------------------------------------------------
module csr_dpath (
  input  logic                                clk,
  input  logic                                rst_n,
  input  csr_pkg::csr_cmd_t                   cmd,
  output csr_pkg::csr_sts_t                   sts,
  input  logic                                cfg_we,
  input  logic                                cfg_index,
  input  logic [63:0]                         cfg_wdata,
  input  logic                                in_op,
  input  logic [csr_pkg::KEY_W-1:0]           in_key,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [csr_pkg::OUT_TDATA_W-1:0]     out_tdata
);
  import csr_pkg::*;

  logic [KEY_W-1:0]  mem [SLOT_COUNT];

  logic [ADDR_W-1:0] base_r;
  logic [63:0]       handler_r;
  logic              op_r;
  logic [KEY_W-1:0]  key_r;
  logic [CNT_W-1:0]  ctr_r;
  logic              rd_valid_r;
  logic [SLOT_W-1:0] rd_idx_r;
  logic [KEY_W-1:0]  rd_data_r;
  logic              found_r;
  logic [SLOT_W-1:0] match_r;
  logic              have_free_r;
  logic [SLOT_W-1:0] free_r;
  logic              out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r;

  logic              issue;
  logic              mem_we;
  logic [SLOT_W-1:0] mem_waddr;
  logic [KEY_W-1:0]  mem_wdata;
  logic              wr_ok;
  csr_status_t       res_status;
  logic [SLOT_W-1:0] res_slot;
  logic [ADDR_W-1:0] res_addr;
  logic [63:0]       res_target;
  logic [63:0]       res_handler;
  logic [63:0]       slot_wide;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r    <= '0;
      handler_r <= '0;
    end else if (cfg_we) begin
      if (csr_cfg_idx_t'(cfg_index) == CFG_ENTRY_BASE) begin
        base_r <= cfg_wdata;
      end else begin
        handler_r <= cfg_wdata;
      end
    end
  end

  assign issue = cmd.scan_issue && (ctr_r != CNT_W'(SLOT_COUNT));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctr_r <= '0;
    end else if (cmd.ctr_clear) begin
      ctr_r <= '0;
    end else if (cmd.clr_write || issue) begin
      ctr_r <= ctr_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r  <= in_op;
      key_r <= in_key;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_valid_r <= 1'b0;
    end else begin
      rd_valid_r <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      rd_data_r <= mem[ctr_r[SLOT_W-1:0]];
      rd_idx_r  <= ctr_r[SLOT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      found_r     <= 1'b0;
      have_free_r <= 1'b0;
      match_r     <= '0;
      free_r      <= '0;
    end else if (rd_valid_r) begin
      if (!found_r && rd_data_r == key_r) begin
        found_r <= 1'b1;
        match_r <= rd_idx_r;
      end
      if (!have_free_r && rd_data_r == '0) begin
        have_free_r <= 1'b1;
        free_r      <= rd_idx_r;
      end
    end
  end

  always_comb begin
    res_status  = ST_OK;
    res_slot    = '0;
    wr_ok       = 1'b0;
    res_addr    = '0;
    res_target  = '0;
    res_handler = '0;
    slot_wide   = 64'(free_r);
    priority if (key_r == '0) begin
      res_status = ST_ZERO;
    end else if (csr_op_t'(op_r) == OP_REGISTER) begin
      priority if (found_r) begin
        res_status = ST_DUP;
      end else if (!have_free_r) begin
        res_status = ST_FULL;
      end else begin
        wr_ok       = 1'b1;
        res_slot    = free_r;
        res_addr    = base_r + (slot_wide << 4);
        res_target  = key_r;
        res_handler = handler_r;
      end
    end else begin
      if (!found_r) begin
        res_status = ST_MISSING;
      end else begin
        wr_ok    = 1'b1;
        res_slot = match_r;
      end
    end
  end

  always_comb begin
    mem_we = cmd.clr_write || (cmd.finish && wr_ok);
    if (cmd.clr_write) begin
      mem_waddr = ctr_r[SLOT_W-1:0];
      mem_wdata = '0;
    end else if (csr_op_t'(op_r) == OP_REGISTER) begin
      mem_waddr = free_r;
      mem_wdata = key_r;
    end else begin
      mem_waddr = match_r;
      mem_wdata = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_data_r <= OUT_TDATA_W'({res_handler, res_target, res_addr,
                                  IDX_OUT_W'(64'(res_slot)), res_status});
    end
  end

  assign sts.clr_last  = (ctr_r == CNT_W'(SLOT_COUNT - 1));
  assign sts.scan_done = (ctr_r == CNT_W'(SLOT_COUNT)) && !rd_valid_r;
  assign sts.key_zero  = (key_r == '0);
  assign sts.out_free  = !out_valid_r || out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ----- tb/callback_slot_registry_tb.sv -----
// ----------------------------------------------------------------------------
// callback_slot_registry_tb
// Drives register and unregister beats into the slot registry. A scoreboard
// keeps its own copy of the key table and settings, predicts the status,
// slot, entry address and data words for each accepted beat, and compares
// every result beat field by field. It runs three phases with different
// settings and idle patterns on both stream sides.
// ----------------------------------------------------------------------------
module callback_slot_registry_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import csr_pkg::*;

  typedef struct {
    csr_status_t            status;
    logic [IDX_OUT_W-1:0]   slot;
    logic [ADDR_W-1:0]      entry_addr;
    logic [KEY_W-1:0]       target;
    logic [ADDR_W-1:0]      handler;
  } slot_result_t;

  class slot_registry_scoreboard;
    logic [KEY_W-1:0]  slot_keys [SLOT_COUNT];
    logic [ADDR_W-1:0] entry_base;
    logic [ADDR_W-1:0] handler_addr;
    slot_result_t      expected_q [$];
    int unsigned       mismatches;

    function new();
      foreach (slot_keys[i]) slot_keys[i] = '0;
      entry_base   = '0;
      handler_addr = '0;
      mismatches   = 0;
    endfunction

    function void set_config(logic [ADDR_W-1:0] base, logic [ADDR_W-1:0] handler);
      entry_base   = base;
      handler_addr = handler;
    endfunction

    function void note_input(csr_op_t op, logic [KEY_W-1:0] key);
      slot_result_t res;
      int hit;
      int free_idx;
      res = '{ST_OK, '0, '0, '0, '0};
      hit = -1;
      free_idx = -1;
      if (key == '0) begin
        res.status = ST_ZERO;
      end else begin
        foreach (slot_keys[i]) begin
          if (hit < 0 && slot_keys[i] == key) hit = i;
          if (free_idx < 0 && slot_keys[i] == '0) free_idx = i;
        end
        if (op == OP_REGISTER) begin
          if (hit >= 0) begin
            res.status = ST_DUP;
          end else if (free_idx < 0) begin
            res.status = ST_FULL;
          end else begin
            slot_keys[free_idx] = key;
            res.slot       = IDX_OUT_W'(free_idx);
            res.entry_addr = entry_base + (64'(free_idx) << 4);
            res.target     = key;
            res.handler    = handler_addr;
          end
        end else begin
          if (hit < 0) begin
            res.status = ST_MISSING;
          end else begin
            slot_keys[hit] = '0;
            res.slot = IDX_OUT_W'(hit);
          end
        end
      end
      expected_q.push_back(res);
    endfunction

    function void compare_field(string field, logic [63:0] exp_v, logic [63:0] act_v);
      if (exp_v !== act_v) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: %s mismatch: expected %h, got %h", $realtime, field, exp_v, act_v);
      end
    endfunction

    function void check_result(logic [OUT_TDATA_W-1:0] beat);
      slot_result_t exp_r;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result beat with nothing expected: %h", $realtime, beat);
        return;
      end
      exp_r = expected_q.pop_front();
      compare_field("status", 64'(exp_r.status), 64'(beat[2:0]));
      compare_field("slot_index", 64'(exp_r.slot), 64'(beat[14:3]));
      compare_field("entry_address", exp_r.entry_addr, beat[78:15]);
      compare_field("write_target", exp_r.target, beat[142:79]);
      compare_field("write_handler", exp_r.handler, beat[206:143]);
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   cfg_we;
  logic                   cfg_index;
  logic [63:0]            cfg_wdata;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [63:0]            in_tdata;   // key
  logic                   in_tuser;   // operation
  logic                   out_tvalid;
  logic                   out_tready;
  // status, slot_index, entry_address, write_target, write_handler, zero pad
  logic [OUT_TDATA_W-1:0] out_tdata;

  slot_registry_scoreboard sb;
  int send_idle;
  int recv_idle;

  callback_slot_registry uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) sb.check_result(out_tdata);
      out_tready <= ($urandom_range(0, 99) >= recv_idle);
    end
  end

  task automatic send_item(csr_op_t op, logic [63:0] key);
    while ($urandom_range(0, 99) < send_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= key;
    do @(posedge clk); while (!in_tready);
    sb.note_input(op, key);
  endtask

  // hold the input side until every pending result has arrived
  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic configure(logic [63:0] base, logic [63:0] handler);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_ENTRY_BASE;
    cfg_wdata <= base;
    @(posedge clk);
    cfg_index <= CFG_HANDLER;
    cfg_wdata <= handler;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_config(base, handler);
  endtask

  task automatic random_item(ref logic [63:0] key_pool [16]);
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 50)
      send_item(OP_REGISTER, key_pool[$urandom_range(0, 15)]);
    else if (pick < 85)
      send_item(OP_UNREGISTER, key_pool[$urandom_range(0, 15)]);
    else if (pick < 92)
      send_item(OP_REGISTER, {$urandom, $urandom});
    else if (pick < 96)
      send_item(OP_UNREGISTER, {$urandom, $urandom});
    else
      send_item(csr_op_t'($urandom_range(0, 1)), '0);
  endtask

  initial begin
    #40_000_000;
    $display("simulation failed");
    $finish;
  end

  initial begin
    logic [63:0] key_pool [16];
    sb = new();
    send_idle  = 17;
    recv_idle  = 74;
    rst_n     <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_index <= CFG_ENTRY_BASE;
    cfg_wdata <= '0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= OP_REGISTER;
    out_tready <= 1'b0;
    key_pool[0] = 64'h1;
    key_pool[1] = '1;
    for (int i = 2; i < 16; i++) key_pool[i] = {$urandom, $urandom};
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);

    configure('1, '1);
    send_item(OP_REGISTER, '0);
    send_item(OP_UNREGISTER, '0);
    send_item(OP_UNREGISTER, '1);
    send_item(OP_REGISTER, 64'h1);
    send_item(OP_REGISTER, '1);
    send_item(OP_REGISTER, 64'h8000_0000_0000_0000);
    send_item(OP_REGISTER, 64'h1);
    send_item(OP_UNREGISTER, 64'h1);
    send_item(OP_REGISTER, 64'hAAAA_AAAA_AAAA_AAAA);
    send_item(OP_REGISTER, 64'h5555_5555_5555_5555);
    send_item(OP_UNREGISTER, '1);
    send_item(OP_UNREGISTER, '1);
    send_item(OP_REGISTER, 64'hFFFF_FFFF_FFFF_FFFE);
    send_item(OP_UNREGISTER, 64'h8000_0000_0000_0000);
    send_item(OP_UNREGISTER, 64'hAAAA_AAAA_AAAA_AAAA);
    send_item(OP_REGISTER, 64'h5555_5555_5555_5555);
    send_item(OP_UNREGISTER, 64'h5555_5555_5555_5555);
    send_item(OP_UNREGISTER, 64'hFFFF_FFFF_FFFF_FFFE);
    for (int n = 0; n < 30; n++) random_item(key_pool);
    drain();

    send_idle = 74;
    recv_idle = 17;
    configure('0, '0);
    for (int n = 0; n < 45; n++) random_item(key_pool);
    drain();

    send_idle = 0;
    recv_idle = 0;
    configure({$urandom, $urandom}, {$urandom, $urandom});
    for (int n = 0; n < 48; n++) begin
      if (n == 24) drain();
      random_item(key_pool);
    end
    drain();
    repeat (8) @(posedge clk);

    if (sb.mismatches == 0 && sb.pending() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

// ----- callback_slot_registry.f -----
rtl/csr_pkg.sv
rtl/csr_ctrl.sv
rtl/csr_dpath.sv
rtl/callback_slot_registry.sv
tb/callback_slot_registry_tb.sv
